### rtl/core/antp_pkg.sv
package antp_pkg;

  // Largest number of note-offs that one all-notes-off request emits.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);

  localparam int unsigned CH_W  = 4;
  localparam int unsigned KEY_W = 7;
  localparam int unsigned AMT_W = 7;

  // Request type codes.
  localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_CC       = 2'd2;
  localparam logic [1:0] REQ_PANIC    = 2'd3;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_CC       = 2'd2
  } kind_e;

  // Operation broadcast to every slot cell.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ON    = 2'd1,
    CMD_OFF   = 2'd2,
    CMD_PANIC = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [CH_W-1:0]   channel;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  // Handed from each cell to the next higher one.
  typedef struct packed {
    logic              free_seen;  // a free slot exists below
    logic              hit_seen;   // a matching active slot exists below
    logic              act_seen;   // an active slot exists below
    logic              act2_seen;  // two or more active slots exist below
    logic [CH_W-1:0]   channel;    // channel of the lowest active slot
    logic [KEY_W-1:0]  key;        // key of the lowest active slot
  } chain_t;

endpackage

### rtl/core/antp_req_if.sv
interface antp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] channel;
  logic [6:0] key;
  logic [6:0] amount;

  modport source (output valid, req_type, channel, key, amount, input ready);
  modport sink   (input valid, req_type, channel, key, amount, output ready);
endinterface

### rtl/core/antp_msg_if.sv
interface antp_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [3:0] out_channel;
  logic [6:0] out_key;
  logic [6:0] out_amount;
  logic       last;

  modport source (output valid, msg_kind, out_channel, out_key, out_amount, last,
                  input ready);
  modport sink   (input valid, msg_kind, out_channel, out_key, out_amount, last,
                  output ready);
endinterface

### rtl/core/antp_slot_cell.sv
module antp_slot_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  antp_pkg::cmd_t    cmd_i,
  input  antp_pkg::chain_t  chain_i,
  output antp_pkg::chain_t  chain_o
);

  logic                        valid_q, valid_d;
  logic [antp_pkg::CH_W-1:0]   channel_q, channel_d;
  logic [antp_pkg::KEY_W-1:0]  key_q, key_d;
  logic                        hit;

  assign hit = valid_q && (channel_q == cmd_i.channel) && (key_q == cmd_i.key);

  always_comb begin
    chain_o.free_seen = chain_i.free_seen | ~valid_q;
    chain_o.hit_seen  = chain_i.hit_seen | hit;
    chain_o.act_seen  = chain_i.act_seen | valid_q;
    chain_o.act2_seen = chain_i.act2_seen | (valid_q & chain_i.act_seen);
    // Pass the lowest active slot upward, or offer this one.
    if (chain_i.act_seen) begin
      chain_o.channel = chain_i.channel;
      chain_o.key     = chain_i.key;
    end else begin
      chain_o.channel = channel_q;
      chain_o.key     = key_q;
    end
  end

  always_comb begin
    valid_d   = valid_q;
    channel_d = channel_q;
    key_d     = key_q;
    case (cmd_i.op)
      antp_pkg::CMD_ON: begin
        if (!valid_q && !chain_i.free_seen) begin
          valid_d   = 1'b1;
          channel_d = cmd_i.channel;
          key_d     = cmd_i.key;
        end
      end
      antp_pkg::CMD_OFF: begin
        if (hit && !chain_i.hit_seen) begin
          valid_d = 1'b0;
        end
      end
      antp_pkg::CMD_PANIC: begin
        if (valid_q && !chain_i.act_seen) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    channel_q <= channel_d;
    key_q     <= key_d;
  end

endmodule

### rtl/core/antp_slot_row.sv
module antp_slot_row #(
  parameter int unsigned NOTE_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  antp_pkg::cmd_t    cmd_i,
  output antp_pkg::chain_t  top_o
);

  antp_pkg::chain_t chain [NOTE_SLOTS+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < NOTE_SLOTS; i++) begin : g_cell
    antp_slot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_i),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  assign top_o = chain[NOTE_SLOTS];

endmodule

### rtl/core/active_note_tracker_with_panic.sv
// A note-on, note-off or control change loads the output register at the edge that takes
//   its request; a panic first enters the panic state, which loads its first note-off,
//   and a panic on an empty table emits nothing.
// Throughput while the sink keeps up: one single-message request per cycle; a panic
//   emits one note-off per cycle, up to MAX_RESULTS, and holds off new requests till done.
// Reset clears every slot valid bit at once; the slot search ripples combinationally.
module active_note_tracker_with_panic #(
  parameter int unsigned NOTE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  antp_req_if.sink    req_i,
  antp_msg_if.source  msg_o
);

  // Control: idle takes requests, panic drains active slots one per cycle while the output is free.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PANIC = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [antp_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  // Output register holds one message until the sink takes it.
  logic                          out_valid_q, out_valid_d;
  logic [1:0]                    kind_q, kind_d;
  logic [antp_pkg::CH_W-1:0]     ch_q, ch_d;
  logic [antp_pkg::KEY_W-1:0]    key_q, key_d;
  logic [antp_pkg::AMT_W-1:0]    amt_q, amt_d;
  logic                          last_q, last_d;

  logic                          out_free;
  logic                          accept;
  logic                          panic_last;
  antp_pkg::cmd_t                cmd;
  antp_pkg::chain_t              row_top;

  // The output slot is free when empty or being drained this cycle.
  assign out_free    = !out_valid_q || msg_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;

  // Stop the sweep on the final active slot or at the result limit.
  assign panic_last = !row_top.act2_seen ||
                      (cnt_q == antp_pkg::CNT_W'(antp_pkg::MAX_RESULTS - 1));

  antp_slot_row #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .top_o  (row_top)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !msg_o.ready;
    kind_d      = kind_q;
    ch_d        = ch_q;
    key_d       = key_q;
    amt_d       = amt_q;
    last_d      = last_q;
    cmd.op      = antp_pkg::CMD_NONE;
    cmd.channel = req_i.channel;
    cmd.key     = req_i.key;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Forward single messages as they came; panic only starts the sweep.
          ch_d   = req_i.channel;
          key_d  = req_i.key;
          amt_d  = req_i.amount;
          last_d = 1'b1;
          case (req_i.req_type)
            antp_pkg::REQ_NOTE_ON: begin
              cmd.op      = antp_pkg::CMD_ON;
              kind_d      = antp_pkg::KIND_NOTE_ON;
              out_valid_d = 1'b1;
            end
            antp_pkg::REQ_NOTE_OFF: begin
              cmd.op      = antp_pkg::CMD_OFF;
              kind_d      = antp_pkg::KIND_NOTE_OFF;
              out_valid_d = 1'b1;
            end
            antp_pkg::REQ_CC: begin
              kind_d      = antp_pkg::KIND_CC;
              out_valid_d = 1'b1;
            end
            default: begin
              // All notes off: emit nothing if no slot is sounding.
              cnt_d = '0;
              if (row_top.act_seen) begin
                state_d = ST_PANIC;
              end
            end
          endcase
        end
      end
      ST_PANIC: begin
        if (out_free) begin
          // Emit and clear the lowest active slot.
          cmd.op      = antp_pkg::CMD_PANIC;
          out_valid_d = 1'b1;
          kind_d      = antp_pkg::KIND_NOTE_OFF;
          ch_d        = row_top.channel;
          key_d       = row_top.key;
          amt_d       = '0;
          last_d      = panic_last;
          cnt_d       = cnt_q + 1'b1;
          if (panic_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ch_q   <= ch_d;
    key_q  <= key_d;
    amt_q  <= amt_d;
    last_q <= last_d;
  end

  assign msg_o.valid       = out_valid_q;
  assign msg_o.msg_kind    = kind_q;
  assign msg_o.out_channel = ch_q;
  assign msg_o.out_key     = key_q;
  assign msg_o.out_amount  = amt_q;
  assign msg_o.last        = last_q;

endmodule
